// ===== rtl/sem_pkg.sv =====
// shared types and constants for the rgb sobel edge magnitude block
// no dependencies
package sem_pkg;
    localparam int CH_W   = 8;
    localparam int GRAD_W = 11;
    localparam int SQ_W   = 22;
    localparam int ROOT_W = 11;
    localparam int CFG_W  = 12;

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

    typedef logic [CH_W-1:0] chan_t;

    // one column of the window for one channel: top, mid, bottom
    typedef struct packed {
        chan_t top;
        chan_t mid;
        chan_t bot;
    } col3_t;

    // position and tags riding with a window through the lanes
    typedef struct packed {
        logic        valid;
        logic [9:0]  col;
        logic [11:0] row;
        logic        frame_end;
    } tag_t;
endpackage

// ===== rtl/sem_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/sem_lane.sv =====
// one channel lane: sobel gradients, squares, pipelined integer square root
// depends on sem_pkg
module sem_lane
    import sem_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  col3_t c0,
    input  col3_t c1,
    input  col3_t c2,
    output chan_t mag
);
    localparam int STEPS = ROOT_W;

    logic signed [GRAD_W:0] gx_reg, gy_reg;
    logic [SQ_W-1:0]        sq_reg;

    logic [SQ_W-1:0]   rem_reg  [STEPS];
    logic [ROOT_W-1:0] root_reg [STEPS];
    logic [SQ_W-1:0]   rem_in   [STEPS];
    logic [ROOT_W-1:0] root_in  [STEPS];
    logic [SQ_W+1:0]   trial    [STEPS];

    // gradients; window column 0 is leftmost
    always_ff @(posedge aclk) begin
        if (en) begin
            gx_reg <= ($signed({4'd0, c2.top}) + $signed({3'd0, c2.mid, 1'b0})
                       + $signed({4'd0, c2.bot}))
                    - ($signed({4'd0, c0.top}) + $signed({3'd0, c0.mid, 1'b0})
                       + $signed({4'd0, c0.bot}));
            gy_reg <= ($signed({4'd0, c0.top}) + $signed({3'd0, c1.top, 1'b0})
                       + $signed({4'd0, c2.top}))
                    - ($signed({4'd0, c0.bot}) + $signed({3'd0, c1.bot, 1'b0})
                       + $signed({4'd0, c2.bot}));
        end
    end

    // sum of squares
    logic [GRAD_W-1:0] ax, ay;
    always_comb begin
        ax = gx_reg[GRAD_W] ? GRAD_W'(-gx_reg) : gx_reg[GRAD_W-1:0];
        ay = gy_reg[GRAD_W] ? GRAD_W'(-gy_reg) : gy_reg[GRAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= SQ_W'(ax * ax) + SQ_W'(ay * ay);
        end
    end

    // stage inputs and trial values for the square root
    always_comb begin
        for (int i = 0; i < STEPS; i++) begin
            if (i == 0) begin
                rem_in[i]  = sq_reg;
                root_in[i] = '0;
            end else begin
                rem_in[i]  = rem_reg[i-1];
                root_in[i] = root_reg[i-1];
            end
            trial[i] = {{(SQ_W-ROOT_W){1'b0}}, root_in[i], 2'b01} << (2 * (STEPS - 1 - i));
        end
    end

    // restoring square root, one result bit per stage
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < STEPS; i++) begin
                if ({2'b0, rem_in[i]} >= trial[i]) begin
                    rem_reg[i]  <= rem_in[i] - SQ_W'(trial[i]);
                    root_reg[i] <= {root_in[i][ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[i]  <= rem_in[i];
                    root_reg[i] <= {root_in[i][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // saturate
    assign mag = (root_reg[STEPS-1] > ROOT_W'(255)) ? chan_t'(255)
                                                    : root_reg[STEPS-1][CH_W-1:0];
endmodule

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
// top level: line stores, window, three channel lanes and output merge
// depends on sem_pkg, sem_ram, sem_lane
//
// The block takes one request per clock while the output is not held, pixels
// in raster order, and returns one result for each pixel with the three
// channel magnitudes, the pixel's column and row, and a frame end flag. A
// result is produced once the pixel one row below and one column right has
// been taken, so results trail input by frame_width+1 requests; after the last
// pixel of a frame, frame_width+1 flush requests (action=1) drain the rest.
// A result passes through the line store read, the window stage, the gradient
// stage, the square stage, an 11-stage square root pipeline in each lane and
// the output register.
// The pipeline stalls as a whole when the output is held, so an accepted
// request is never lost. The line stores are block rams with no clearing;
// rows outside the frame read as zero by position. Writing frame_width or
// frame_height restarts the frame and drops pending results.
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // red[7:0], green[15:8], blue[23:16]
    input  logic [23:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red_edge, green_edge, blue_edge, out_col[33:24], out_row[45:34], pad
    output logic [47:0] m_tdata,
    // frame_end
    output logic        m_tlast
);
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int LAT  = 14;

    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic [AW-1:0]  col_reg;
    logic [12:0]    row_reg;

    logic [11:0] eff_w;
    logic [12:0] eff_h;
    always_comb begin
        eff_w = (width_reg == 11'd0) ? 12'd1 : {1'b0, width_reg};
        if ({1'b0, eff_w} > 13'(MAX_WIDTH)) begin
            eff_w = 12'(MAX_WIDTH);
        end
        eff_h = (height_reg == 12'd0) ? 13'd1 : {1'b0, height_reg};
    end

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    logic acc, draining, act;
    assign acc      = s_tvalid && s_tready;
    assign draining = row_reg >= eff_h;
    assign act      = acc && !(s_tuser && !draining);

    logic [23:0] pix;
    assign pix = draining ? 24'd0 : {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    // stage 1: line store read, request registered
    logic [23:0] a_rd, b_rd;
    logic [23:0] pix_s1_reg;
    logic [AW-1:0] col_s1_reg;
    logic [12:0] row_s1_reg;
    logic        act_s1_reg;
    logic        fwd_reg;
    logic [23:0] a_fwd_reg, b_fwd_reg;

    // same column written and read back to back: forward
    logic wr_s1;
    assign wr_s1 = act_s1_reg && (row_s1_reg < eff_h);

    logic [23:0] a_now, b_now;
    assign a_now = fwd_reg ? a_fwd_reg : a_rd;
    assign b_now = fwd_reg ? b_fwd_reg : b_rd;

    sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_ram_a (
        .aclk(aclk), .we(wr_s1 && en), .waddr(col_s1_reg), .wdata(pix_s1_reg),
        .raddr(en ? col_reg : col_s1_reg), .rdata(a_rd)
    );
    sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_ram_b (
        .aclk(aclk), .we(wr_s1 && en), .waddr(col_s1_reg), .wdata(a_now),
        .raddr(en ? col_reg : col_s1_reg), .rdata(b_rd)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_s1_reg <= pix;
            col_s1_reg <= col_reg;
            row_s1_reg <= row_reg;
            fwd_reg    <= wr_s1 && (col_s1_reg == col_reg);
            a_fwd_reg  <= pix_s1_reg;
            b_fwd_reg  <= a_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            act_s1_reg <= 1'b0;
        end else if (en) begin
            act_s1_reg <= act;
        end
    end

    // position counters and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd640;
            height_reg <= 12'd480;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_WIDTH) begin
                width_reg <= cfg_data[10:0];
            end else begin
                height_reg <= cfg_data;
            end
            col_reg <= '0;
            row_reg <= '0;
        end else if (act) begin
            if (col_reg == '0 && row_reg == eff_h + 13'd1) begin
                row_reg <= '0;
            end else if (12'(col_reg) + 12'd1 >= eff_w) begin
                col_reg <= '0;
                row_reg <= row_reg + 13'd1;
            end else begin
                col_reg <= col_reg + AW'(1);
            end
        end
    end

    // stage 2: window shift
    logic [23:0] top, mid, bot;
    always_comb begin
        top = (row_s1_reg >= 13'd2 && row_s1_reg - 13'd2 < eff_h) ? b_now : 24'd0;
        mid = (row_s1_reg >= 13'd1 && row_s1_reg - 13'd1 < eff_h) ? a_now : 24'd0;
        bot = (row_s1_reg < eff_h) ? pix_s1_reg : 24'd0;
    end

    logic [71:0] w1_reg, w2_reg;
    logic [71:0] e0_reg, e1_reg, e2_reg;
    tag_t        tag_reg;
    logic        restart_s1;
    assign restart_s1 = col_s1_reg == '0 && row_s1_reg == eff_h + 13'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            w1_reg  <= '0;
            w2_reg  <= '0;
            tag_reg <= '0;
        end else if (en) begin
            if (!act_s1_reg) begin
                tag_reg.valid <= 1'b0;
            end else if (col_s1_reg == '0) begin
                e0_reg <= w1_reg;
                e1_reg <= w2_reg;
                e2_reg <= '0;
                tag_reg.valid     <= row_s1_reg >= 13'd2;
                tag_reg.col       <= 10'(eff_w - 12'd1);
                tag_reg.row       <= 12'(row_s1_reg - 13'd2);
                tag_reg.frame_end <= (row_s1_reg - 13'd2) == (eff_h - 13'd1);
                w1_reg <= '0;
                // frame restart clears the whole window
                w2_reg <= restart_s1 ? 72'd0 : {top, mid, bot};
            end else begin
                e0_reg <= w1_reg;
                e1_reg <= w2_reg;
                e2_reg <= {top, mid, bot};
                tag_reg.valid     <= row_s1_reg >= 13'd1;
                tag_reg.col       <= 10'(col_s1_reg - AW'(1));
                tag_reg.row       <= 12'(row_s1_reg - 13'd1);
                tag_reg.frame_end <= 1'b0;
                w1_reg <= w2_reg;
                w2_reg <= {top, mid, bot};
            end
        end
    end

    // three lanes, one per channel
    chan_t mag [3];
    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        localparam int SH = 16 - 8 * ch;
        col3_t c0, c1, c2;
        always_comb begin
            c0 = '{e0_reg[48+SH +: 8], e0_reg[24+SH +: 8], e0_reg[SH +: 8]};
            c1 = '{e1_reg[48+SH +: 8], e1_reg[24+SH +: 8], e1_reg[SH +: 8]};
            c2 = '{e2_reg[48+SH +: 8], e2_reg[24+SH +: 8], e2_reg[SH +: 8]};
        end
        sem_lane u_lane (.aclk(aclk), .en(en), .c0(c0), .c1(c1), .c2(c2),
                         .mag(mag[ch]));
    end

    // tag delay line matching the lane latency
    tag_t tag_d_reg [LAT-1];
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            for (int i = 0; i < LAT - 1; i++) begin
                tag_d_reg[i] <= '0;
            end
        end else if (en) begin
            tag_d_reg[0] <= tag_reg;
            for (int i = 1; i < LAT - 1; i++) begin
                tag_d_reg[i] <= tag_d_reg[i-1];
            end
        end
    end

    // merge stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= tag_d_reg[LAT-2].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= {2'b0, tag_d_reg[LAT-2].row, tag_d_reg[LAT-2].col,
                        mag[2], mag[1], mag[0]};
            m_tlast <= tag_d_reg[LAT-2].frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
endmodule

// ===== rtl/sem_checker.sv =====
// port-level checks for the rgb sobel edge magnitude block
// depends on sobel_edge_magnitude_rgb ports
module sem_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_we,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);
    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn || cfg_we)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("held result changed");

    // input is open whenever the output holds no result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

    // padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:46] == 2'b00)
        else $error("padding bits set");
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
    .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
